@@ rtl/srdz_pkg.sv @@
`timescale 1ns / 1ps

package srdz_pkg;

	// Field and register widths
	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 15;
	localparam int IDX_W  = 1;

	// Magnitudes and squares: |c| <= 2^15, c^2 <= 2^30, x^2 + y^2 <= 2^31
	localparam int MAG_W  = IN_W + 1;
	localparam int SQR_W  = 2 * (IN_W - 1) + 1;
	localparam int SUM_W  = SQR_W + 1;
	localparam int DZSQ_W = 2 * CFG_W;

	// Fixed-point formats: length in Q.16, scale and unit vector in Q.30
	localparam int LEN_FRAC   = 16;
	localparam int SCALE_BITS = 30;
	localparam int OUT_FRAC_BITS_DEF = 15;

	// Square root of (sum << 32): 32 result bits, two per stage
	localparam int ROOT_W      = 32;
	localparam int SQRT_REM_W  = ROOT_W + 2;
	localparam int SQRT_STEPS  = 2;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

	// Restoring divider: three lanes, 32 quotient bits, two per stage
	localparam int DIV_W      = 32;
	localparam int QUO_W      = 32;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;
	localparam int DIV_LANES  = 3;
	localparam int LANE_X     = 0;
	localparam int LANE_Y     = 1;
	localparam int LANE_S     = 2;

	// Unit lane divides (|c| << 14) << 32 by the length: |c| * 2^46 / len
	localparam int UNIT_PRE_SHIFT = LEN_FRAC + SCALE_BITS - QUO_W;
	// Scale lane yields (len - dead zone) * 2^32 / span; drop two bits for Q.30
	localparam int SCALE_DROP     = QUO_W - SCALE_BITS;
	localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(1) << SCALE_BITS;

	// Product of two Q.30 factors
	localparam int FACT_W = SCALE_BITS + 1;
	localparam int PROD_W = 2 * FACT_W;
	localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'((1 << (OUT_W - 1)) - 1);
	localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(1 << (OUT_W - 1));

	// Register map and reset values
	localparam logic [IDX_W-1:0] REG_FULL_SCALE = 1'b0;
	localparam logic [IDX_W-1:0] REG_DEAD_ZONE  = 1'b1;
	localparam logic [CFG_W-1:0] FULL_SCALE_RST = 15'd1000;
	localparam logic [CFG_W-1:0] DEAD_ZONE_RST  = 15'd200;
	localparam logic [DZSQ_W-1:0] DZSQ_RST = DZSQ_W'(200 * 200);
	localparam logic [DIV_W-1:0] SPAN_RST = DIV_W'((1000 - 200) << LEN_FRAC);

	// Sideband that rides along the root pipeline
	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             neg_x;
		logic             neg_z;
		logic             active;
	} sqrt_side_t;

	// Sideband that rides along the divider pipeline
	typedef struct packed {
		logic neg_x;
		logic neg_z;
		logic active;
		logic sat;
		logic zero;
	} div_side_t;

	typedef struct packed {
		logic [SQRT_REM_W-1:0] rem;
		logic [ROOT_W-1:0]     root;
		logic [SUM_W-1:0]      rad;
	} sqrt_state_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_state_t;

	// One digit of the bit-pair square root; radicand pairs come off the top of rad
	function automatic sqrt_state_t sqrt_step(sqrt_state_t st);
		logic [SQRT_REM_W-1:0] nxt;
		logic [SQRT_REM_W-1:0] trial;
		sqrt_state_t           r;
		nxt   = {st.rem[SQRT_REM_W-3:0], st.rad[SUM_W-1 -: 2]};
		trial = {st.root, 2'b01};
		r.rad = st.rad << 2;
		if (nxt >= trial) begin
			r.rem  = nxt - trial;
			r.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = nxt;
			r.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// One restoring division step, zero shifted in
	function automatic div_state_t div_step(div_state_t st, logic [DIV_W-1:0] dvs);
		logic [DIV_W:0] t;
		div_state_t     r;
		t = {st.rem, 1'b0};
		if (t >= {1'b0, dvs}) begin
			r.rem = DIV_W'(t - {1'b0, dvs});
			r.quo = {st.quo[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = t[DIV_W-1:0];
			r.quo = {st.quo[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/stick_radial_dead_zone_top.sv @@
`timescale 1ns / 1ps

// Radial dead zone with rescale for one analog stick sample.
// Sample channel: sample_valid/sample_ready carry stick_x, stick_y (signed raw).
// Result channel: dir_valid/dir_ready carry dir_x, dir_z (signed, OUT_FRAC_BITS
// fraction bits, saturated to 16 bits) and active. Below the dead zone both
// directions are zero and active is low; dir_z is the negated vertical axis.
// Config port: cfg_we writes cfg_data into full_scale (index 0) or dead_zone
// (index 1) at once; write only while no beat is in flight.
// Pipeline: an accepted sample passes through square and sum (2), a 16-stage
// root of two bits per stage, a prep stage, a 16-stage three-lane divider of
// two bits per stage, then multiply, round and the output register.
// Throughput is one sample per cycle while the pipe is not stalled.
// Stall: a full output register with dir_ready low freezes the pipe only when
// the stage behind it holds a beat; bubbles still drain and sample_ready stays
// high while the output register is empty.
// Reset: arst_n clears all valid bits and loads full_scale 1000, dead_zone 200.
module stick_radial_dead_zone_top #(
	parameter int OUT_FRAC_BITS = srdz_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srdz_pkg::IDX_W-1:0]          cfg_index,
	input  logic [srdz_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [srdz_pkg::IN_W-1:0]    stick_x,
	input  logic signed [srdz_pkg::IN_W-1:0]    stick_y,
	output logic                                dir_valid,
	input  logic                                dir_ready,
	output logic signed [srdz_pkg::OUT_W-1:0]   dir_x,
	output logic signed [srdz_pkg::OUT_W-1:0]   dir_z,
	output logic                                active
);
	import srdz_pkg::*;

	localparam int RND_SHIFT = 2 * SCALE_BITS - OUT_FRAC_BITS;
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SHIFT - 1);

	// Saturate a magnitude and apply the sign
	function automatic logic [OUT_W-1:0] sat_sign(logic [PROD_W-1:0] m, logic neg);
		logic [OUT_W:0] mm;
		if (neg) begin
			mm = (m > NEG_LIMIT) ? NEG_LIMIT[OUT_W:0] : m[OUT_W:0];
			return OUT_W'((~mm) + 1'b1);
		end else begin
			mm = (m > POS_LIMIT) ? POS_LIMIT[OUT_W:0] : m[OUT_W:0];
			return mm[OUT_W-1:0];
		end
	endfunction

	// Configuration and derived constants
	logic [CFG_W-1:0]  full_scale_q;
	logic [CFG_W-1:0]  dead_zone_q;
	logic [DZSQ_W-1:0] dz_sq_q;
	logic [DIV_W-1:0]  span_q;
	logic [DIV_W-1:0]  f16;
	logic [DIV_W-1:0]  d16;

	assign f16 = DIV_W'(full_scale_q) << LEN_FRAC;
	assign d16 = DIV_W'(dead_zone_q) << LEN_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			dead_zone_q  <= DEAD_ZONE_RST;
			dz_sq_q      <= DZSQ_RST;
			span_q       <= SPAN_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FULL_SCALE: full_scale_q <= cfg_data;
					REG_DEAD_ZONE:  dead_zone_q  <= cfg_data;
				endcase
			end
			dz_sq_q <= DZSQ_W'(dead_zone_q) * DZSQ_W'(dead_zone_q);
			span_q  <= f16 - d16;
		end
	end

	// Pipe advance: hold only when a beat would run into a stalled output
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en           = !v_s6 || dir_ready || !v_s5;
	assign sample_ready = en;

	// Stage 1: absolute values and squares
	logic signed [MAG_W-1:0] xe, ye;
	logic [MAG_W-1:0]        ax_c, ay_c;
	logic [2*MAG_W-1:0]      sqx_c, sqy_c;
	logic [MAG_W-1:0]        ax_s1, ay_s1;
	logic [SQR_W-1:0]        sqx_s1, sqy_s1;
	logic                    negx_s1, negz_s1;

	assign xe    = MAG_W'(stick_x);
	assign ye    = MAG_W'(stick_y);
	assign ax_c  = xe[MAG_W-1] ? MAG_W'(-xe) : MAG_W'(xe);
	assign ay_c  = ye[MAG_W-1] ? MAG_W'(-ye) : MAG_W'(ye);
	assign sqx_c = (2*MAG_W)'(ax_c) * (2*MAG_W)'(ax_c);
	assign sqy_c = (2*MAG_W)'(ay_c) * (2*MAG_W)'(ay_c);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			sqx_s1  <= sqx_c[SQR_W-1:0];
			sqy_s1  <= sqy_c[SQR_W-1:0];
			negx_s1 <= stick_x[IN_W-1];
			negz_s1 <= !stick_y[IN_W-1] && (|stick_y);
		end
	end

	// Stage 2: squared length and exact dead zone test
	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] sum_s2;
	sqrt_side_t       side_s2;

	assign sum_c = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_c;
			side_s2 <= '{ax: ax_s1, ay: ay_s1, neg_x: negx_s1, neg_z: negz_s1,
				active: (sum_c >= SUM_W'(dz_sq_q))};
		end
	end

	// Length in Q.16
	logic              v_r;
	logic [ROOT_W-1:0] lq;
	sqrt_side_t        side_r;

	srdz_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rad       (sum_s2),
		.in_side   (side_s2),
		.out_valid (v_r),
		.root      (lq),
		.out_side  (side_r)
	);

	// Stage 3: divider operands, saturation and zero-length flags
	logic [DIV_LANES-1:0][DIV_W-1:0] dvd_s3, dvs_s3;
	div_side_t                       side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s3[LANE_X] <= DIV_W'(side_r.ax) << UNIT_PRE_SHIFT;
			dvd_s3[LANE_Y] <= DIV_W'(side_r.ay) << UNIT_PRE_SHIFT;
			dvd_s3[LANE_S] <= lq - d16;
			dvs_s3[LANE_X] <= lq;
			dvs_s3[LANE_Y] <= lq;
			dvs_s3[LANE_S] <= span_q;
			side_s3        <= '{neg_x: side_r.neg_x, neg_z: side_r.neg_z,
				active: side_r.active, sat: (lq >= f16), zero: (lq == '0)};
		end
	end

	// Unit vector and scale
	logic                            v_d;
	logic [DIV_LANES-1:0][QUO_W-1:0] quo;
	div_side_t                       side_d;

	srdz_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.dividend  (dvd_s3),
		.divisor   (dvs_s3),
		.in_side   (side_s3),
		.out_valid (v_d),
		.quotient  (quo),
		.out_side  (side_d)
	);

	// Stage 4: unit times scale
	logic [FACT_W-1:0] sq_c;
	logic [PROD_W-1:0] px_c, py_c;
	logic [PROD_W-1:0] px_s4, py_s4;
	div_side_t         side_s4;

	assign sq_c = side_d.sat ? FACT_W'(UNIT_ONE) : FACT_W'(quo[LANE_S][QUO_W-1:SCALE_DROP]);
	assign px_c = PROD_W'(quo[LANE_X][FACT_W-1:0]) * PROD_W'(sq_c);
	assign py_c = PROD_W'(quo[LANE_Y][FACT_W-1:0]) * PROD_W'(sq_c);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4   <= px_c;
			py_s4   <= py_c;
			side_s4 <= side_d;
		end
	end

	// Stage 5: round half up to the output fraction
	logic [PROD_W-1:0] mx_s5, mz_s5;
	div_side_t         side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5   <= (px_s4 + RND_HALF) >> RND_SHIFT;
			mz_s5   <= (py_s4 + RND_HALF) >> RND_SHIFT;
			side_s5 <= side_s4;
		end
	end

	// Valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_r;
			v_s4 <= v_d;
			v_s5 <= v_s4;
		end
	end

	// Stage 6: output register, saturate and sign
	logic [OUT_W-1:0] dirx_s6, dirz_s6;
	logic             act_s6;
	logic             kill_c;

	assign kill_c = !side_s5.active || side_s5.zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en && v_s5) begin
			v_s6 <= 1'b1;
		end else if (dir_ready) begin
			v_s6 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5) begin
			dirx_s6 <= kill_c ? '0 : sat_sign(mx_s5, side_s5.neg_x);
			dirz_s6 <= kill_c ? '0 : sat_sign(mz_s5, side_s5.neg_z);
			act_s6  <= side_s5.active;
		end
	end

	assign dir_valid = v_s6;
	assign dir_x     = dirx_s6;
	assign dir_z     = dirz_s6;
	assign active    = act_s6;

	// Checks
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dir_valid && !active |-> dir_x == '0 && dir_z == '0)
		else $error("inactive result with nonzero direction");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_valid |-> sample_ready)
		else $error("sample stalled with empty output register");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_d && !side_d.zero |-> quo[LANE_X] <= UNIT_ONE && quo[LANE_Y] <= UNIT_ONE)
		else $error("unit vector component above one");

	a_drain_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		dir_valid && dir_ready && !v_s5 |=> !dir_valid)
		else $error("result repeated after it was taken");

endmodule

@@ rtl/srdz_sqrt.sv @@
`timescale 1ns / 1ps

module srdz_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [srdz_pkg::SUM_W-1:0]    rad,
	input  srdz_pkg::sqrt_side_t          in_side,
	output logic                          out_valid,
	output logic [srdz_pkg::ROOT_W-1:0]   root,
	output srdz_pkg::sqrt_side_t          out_side
);
	import srdz_pkg::*;

	// root = floor(sqrt(rad << 32)), SQRT_STEPS digits per stage
	sqrt_state_t              st_s      [SQRT_STAGES];
	sqrt_side_t               side_s    [SQRT_STAGES];
	logic [SQRT_STAGES-1:0]   vld_s;
	sqrt_state_t              stage_in  [SQRT_STAGES];
	sqrt_state_t              stage_out [SQRT_STAGES];

	assign stage_in[0] = '{rem: '0, root: '0, rad: rad};

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		if (g > 0) begin : g_link
			assign stage_in[g] = st_s[g-1];
		end

		always_comb begin
			sqrt_state_t w;
			w = stage_in[g];
			for (int k = 0; k < SQRT_STEPS; k++) begin
				w = sqrt_step(w);
			end
			stage_out[g] = w;
		end

		// valid bit moves with the beat
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				if (g == 0) begin
					vld_s[g] <= in_valid;
				end else begin
					vld_s[g] <= vld_s[(g > 0) ? g - 1 : 0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g] <= stage_out[g];
				if (g == 0) begin
					side_s[g] <= in_side;
				end else begin
					side_s[g] <= side_s[(g > 0) ? g - 1 : 0];
				end
			end
		end
	end

	assign out_valid = vld_s[SQRT_STAGES-1];
	assign root      = st_s[SQRT_STAGES-1].root;
	assign out_side  = side_s[SQRT_STAGES-1];

endmodule

@@ rtl/srdz_div.sv @@
`timescale 1ns / 1ps

module srdz_div (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              en,
	input  logic                                              in_valid,
	input  logic [srdz_pkg::DIV_LANES-1:0][srdz_pkg::DIV_W-1:0] dividend,
	input  logic [srdz_pkg::DIV_LANES-1:0][srdz_pkg::DIV_W-1:0] divisor,
	input  srdz_pkg::div_side_t                               in_side,
	output logic                                              out_valid,
	output logic [srdz_pkg::DIV_LANES-1:0][srdz_pkg::QUO_W-1:0] quotient,
	output srdz_pkg::div_side_t                               out_side
);
	import srdz_pkg::*;

	// Three restoring dividers in lockstep; quotient valid only if dividend < divisor
	div_state_t                            st_s      [DIV_STAGES][DIV_LANES];
	logic [DIV_LANES-1:0][DIV_W-1:0]       dvs_s     [DIV_STAGES];
	div_side_t                             side_s    [DIV_STAGES];
	logic [DIV_STAGES-1:0]                 vld_s;
	div_state_t                            stage_in  [DIV_STAGES][DIV_LANES];
	div_state_t                            stage_out [DIV_STAGES][DIV_LANES];
	logic [DIV_LANES-1:0][DIV_W-1:0]       dvs_in    [DIV_STAGES];

	assign dvs_in[0] = divisor;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g > 0) begin : g_link
			assign dvs_in[g] = dvs_s[g-1];
		end

		for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
			if (g == 0) begin : g_head
				assign stage_in[g][l] = '{rem: dividend[l], quo: '0};
			end else begin : g_tail
				assign stage_in[g][l] = st_s[g-1][l];
			end

			always_comb begin
				div_state_t w;
				w = stage_in[g][l];
				for (int k = 0; k < DIV_STEPS; k++) begin
					w = div_step(w, dvs_in[g][l]);
				end
				stage_out[g][l] = w;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					st_s[g][l] <= stage_out[g][l];
				end
			end
		end

		// valid bit moves with the beat
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				if (g == 0) begin
					vld_s[g] <= in_valid;
				end else begin
					vld_s[g] <= vld_s[(g > 0) ? g - 1 : 0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[g] <= dvs_in[g];
				if (g == 0) begin
					side_s[g] <= in_side;
				end else begin
					side_s[g] <= side_s[(g > 0) ? g - 1 : 0];
				end
			end
		end
	end

	for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
		assign quotient[l] = st_s[DIV_STAGES-1][l].quo;
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule
